// ===== sv/rse_pkg.sv =====
// Shared types and constants of the RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
package rse_pkg;

  localparam int unsigned WidthDefault  = 1024;
  localparam int unsigned HeightDefault = 1024;

  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CfgW-1:0] ResetWidth  = 11'd640;
  localparam logic [CfgW-1:0] ResetHeight = 11'd480;

  // channel slots inside a packed pixel
  localparam int unsigned ChRed   = 2;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 0;

  localparam logic [7:0]  MagMax   = 8'd255;
  localparam logic [20:0] SatLimit = 21'd65281;

  typedef logic [2:0][7:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [7:0] red_mag;
    logic [7:0] green_mag;
    logic [7:0] blue_mag;
    logic       frame_last;
  } res_t;

  typedef struct packed {
    logic full_rows;  // upper line store holds a row of this frame
    logic mid_ok;     // lower line store holds a row of this frame
    logic final_px;   // last flush transfer of the frame
  } job_flags_t;

endpackage

// ===== sv/rgb_sobel_edge_magnitude.sv =====
// Top level of the streaming RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
// Streams RGB pixels in raster order and returns, per channel, the rounded Sobel
// gradient magnitude saturated to 255, with zero padding at the borders. A result
// trails its pixel by one row plus one pixel; after each frame send image_width+1
// flush transfers (req_type high) to drain the last row, the final result carrying
// frame_last. Sizes are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT; a size write
// restarts the frame and is allowed only while the block is idle. The front end
// classifies each transfer into a two-entry queue; the back end handles each
// transfer as a line-store read and then a window update, plus a hand-off when
// the transfer yields a result, and the magnitude unit works through gradients,
// squares, sum, eight root steps, rounding and the output register per result,
// taking the next window only once its last result has been taken, so the
// bit-serial square root sets the sustained rate.
module rgb_sobel_edge_magnitude import rse_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = WidthDefault,
  parameter int unsigned MAX_HEIGHT = HeightDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output res_t               out_res_o
);

  logic                         restart;
  logic                         job_valid, job_pop;
  logic [$clog2(MAX_WIDTH)-1:0] job_col;
  job_flags_t                   job_flags;
  pix_t                         job_data;
  logic                         mag_idle, mag_start, mag_last;
  win_t                         mag_win;

  // accept and classify transfers, track the raster position
  rse_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .restart_o  (restart),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .job_valid_o(job_valid),
    .job_pop_i  (job_pop),
    .job_col_o  (job_col),
    .job_flags_o(job_flags),
    .job_data_o (job_data)
  );

  // line stores and window
  rse_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .job_valid_i(job_valid),
    .job_pop_o  (job_pop),
    .job_col_i  (job_col),
    .job_flags_i(job_flags),
    .job_data_i (job_data),
    .mag_idle_i (mag_idle),
    .mag_start_o(mag_start),
    .mag_win_o  (mag_win),
    .mag_last_o (mag_last)
  );

  // gradient magnitude and output register
  rse_mag u_mag (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mag_start),
    .idle_o     (mag_idle),
    .win_i      (mag_win),
    .last_i     (mag_last),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule

// ===== sv/rse_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module rse_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rse_front.sv =====
// Front end: configuration, raster position tracking and the job queue.
`timescale 1ns / 1ps
module rse_front import rse_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = WidthDefault,
  parameter int unsigned MAX_HEIGHT = HeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  output logic                          restart_o,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  req_t                          in_req_i,
  output logic                          job_valid_o,
  input  logic                          job_pop_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  job_col_o,
  output job_flags_t                    job_flags_o,
  output pix_t                          job_data_o
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned WBits = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT);
  localparam int unsigned HBits = $clog2(MAX_HEIGHT + 1);

  logic [CfgW-1:0]  width_q, height_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [WBits-1:0] pend_q, pend_d;
  logic [WBits-1:0] w_eff, k, next_col;
  logic [HBits-1:0] h_eff;
  logic             flush, accept, cfg_hit;

  logic [ColW-1:0]  cur_col;
  job_flags_t       cur_flags;
  pix_t             cur_data;

  // clamp the frame size to the supported range
  always_comb begin
    if (width_q < 11'd2) begin
      w_eff = WBits'(2);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WBits'(MAX_WIDTH);
    end else begin
      w_eff = WBits'(width_q);
    end
    if (height_q < 11'd2) begin
      h_eff = HBits'(2);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HBits'(MAX_HEIGHT);
    end else begin
      h_eff = HBits'(height_q);
    end
  end

  assign flush    = (pend_q != '0);
  assign k        = w_eff + WBits'(1) - pend_q;
  assign next_col = WBits'(col_q) + WBits'(1);
  assign cfg_hit  = cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH ||
                                 cfg_idx_i == CFG_IMAGE_HEIGHT);
  assign restart_o = cfg_hit;

  // classify the incoming transfer
  always_comb begin
    if (flush) begin
      cur_flags.final_px  = (k >= w_eff);
      cur_col             = cur_flags.final_px ? '0 : ColW'(k);
      cur_flags.full_rows = 1'b1;
      cur_flags.mid_ok    = 1'b1;
      cur_data            = '0;
    end else begin
      cur_flags.final_px  = 1'b0;
      cur_col             = (WBits'(col_q) >= w_eff) ? '0 : col_q;
      cur_flags.full_rows = (32'(row_q) >= 2);
      cur_flags.mid_ok    = (32'(row_q) >= 1);
      cur_data            = in_req_i.req_type ? '0 :
                            {in_req_i.red_in, in_req_i.green_in, in_req_i.blue_in};
    end
  end

  // advance the raster position
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (flush) begin
      pend_d = pend_q - WBits'(1);
    end else if (next_col >= w_eff) begin
      col_d = '0;
      if (HBits'(row_q) + HBits'(1) >= h_eff) begin
        row_d  = '0;
        pend_d = w_eff + WBits'(1);
      end else begin
        row_d = row_q + RowW'(1);
      end
    end else begin
      col_d = ColW'(next_col);
    end
  end

  // two-entry job queue
  logic [ColW-1:0] q_col_q  [2];
  job_flags_t      q_flag_q [2];
  pix_t            q_data_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign in_ready_o  = (count_q != 2'd2);
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = (count_q != 2'd0);
  assign job_col_o   = q_col_q[rd_ptr_q];
  assign job_flags_o = q_flag_q[rd_ptr_q];
  assign job_data_o  = q_data_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_col_q[wr_ptr_q]  <= cur_col;
      q_flag_q[wr_ptr_q] <= cur_flags;
      q_data_q[wr_ptr_q] <= cur_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (cfg_hit) begin
        if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i;
        end
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
      end else if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        pend_q <= pend_d;
      end
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (job_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, accept} - {1'b0, job_pop_i};
    end
  end

endmodule

// ===== sv/rse_back.sv =====
// Back end: line stores and 3x3 window update, hands windows to the magnitude unit.
`timescale 1ns / 1ps
module rse_back import rse_pkg::*; #(
  parameter int unsigned MAX_WIDTH = WidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          job_valid_i,
  output logic                          job_pop_o,
  input  logic [$clog2(MAX_WIDTH)-1:0]  job_col_i,
  input  job_flags_t                    job_flags_i,
  input  pix_t                          job_data_i,
  input  logic                          mag_idle_i,
  output logic                          mag_start_o,
  output win_t                          mag_win_o,
  output logic                          mag_last_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_ISSUE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [ColW-1:0] col_q;
  job_flags_t      flags_q;
  pix_t            data_q;
  win_t            win_q, win_d, emit_win_q, emit_win_d;
  logic            emit_last_q, emit, emit_last;
  pix_t            upper_rd, lower_rd;
  logic            ram_we;

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign ram_we    = (state_q == ST_READ) && !flags_q.final_px;

  rse_ram #(.Width(24), .Depth(MAX_WIDTH)) u_upper (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(col_q),
    .wdata_i(lower_rd),
    .re_i   (job_pop_o),
    .raddr_i(job_col_i),
    .rdata_o(upper_rd)
  );

  rse_ram #(.Width(24), .Depth(MAX_WIDTH)) u_lower (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(col_q),
    .wdata_i(data_q),
    .re_i   (job_pop_o),
    .raddr_i(job_col_i),
    .rdata_o(lower_rd)
  );

  // window update for one job
  always_comb begin
    win_d      = win_q;
    emit_win_d = '0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    if (col_q == '0) begin
      for (int i = 0; i < 3; i++) begin
        emit_win_d[i*3]   = win_q[i*3+1];
        emit_win_d[i*3+1] = win_q[i*3+2];
        emit_win_d[i*3+2] = '0;
      end
      emit      = flags_q.full_rows;
      emit_last = flags_q.final_px;
      win_d     = '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        win_d[i*3]   = win_q[i*3+1];
        win_d[i*3+1] = win_q[i*3+2];
      end
    end
    if (!flags_q.final_px) begin
      win_d[2] = flags_q.full_rows ? upper_rd : '0;
      win_d[5] = flags_q.mid_ok ? lower_rd : '0;
      win_d[8] = data_q;
    end
    if (col_q != '0) begin
      emit_win_d = win_d;
      emit       = flags_q.mid_ok;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = ST_READ;
      ST_READ:  state_d = emit ? ST_ISSUE : ST_IDLE;
      ST_ISSUE: if (mag_idle_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign mag_start_o = (state_q == ST_ISSUE);
  assign mag_win_o   = emit_win_q;
  assign mag_last_o  = emit_last_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      col_q   <= job_col_i;
      flags_q <= job_flags_i;
      data_q  <= job_data_i;
    end
    if (state_q == ST_READ) begin
      emit_win_q  <= emit_win_d;
      emit_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        win_q <= '0;
      end else if (state_q == ST_READ) begin
        win_q <= win_d;
      end
    end
  end

endmodule

// ===== sv/rse_mag.sv =====
// Magnitude unit: Sobel gradients, squares and a bit-per-cycle rounded square root.
`timescale 1ns / 1ps
module rse_mag import rse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic idle_o,
  input  win_t win_i,
  input  logic last_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  typedef enum logic [6:0] {
    M_IDLE  = 7'b0000001,
    M_GRAD  = 7'b0000010,
    M_SQR   = 7'b0000100,
    M_SUM   = 7'b0001000,
    M_ROOT  = 7'b0010000,
    M_ROUND = 7'b0100000,
    M_HOLD  = 7'b1000000
  } mstate_e;

  mstate_e            state_q, state_d;
  win_t               win_q;
  logic               last_q;
  logic signed [10:0] gx_q [3], gy_q [3], gx_d [3], gy_d [3];
  logic [19:0]        sqx_q [3], sqy_q [3], sqx_d [3], sqy_d [3];
  logic [20:0]        s_q [3];
  logic [7:0]         n_q [3], n_d [3], mag_d [3];
  logic [2:0]         it_q;
  logic [7:0]         bitv;
  res_t               res_q;

  assign idle_o      = (state_q == M_IDLE);
  assign out_valid_o = (state_q == M_HOLD);
  assign out_res_o   = res_q;
  assign bitv        = 8'h80 >> it_q;

  always_comb begin
    logic signed [10:0] v [9];
    logic signed [21:0] gxe, gye;
    logic [7:0]         t;
    logic [15:0]        tt;
    logic [16:0]        nn;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        v[i] = signed'({3'b000, win_q[i][ch]});
      end
      gx_d[ch] = (v[2] - v[0]) + ((v[5] - v[3]) <<< 1) + (v[8] - v[6]);
      gy_d[ch] = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
      gxe = 22'(gx_q[ch]);
      gye = 22'(gy_q[ch]);
      sqx_d[ch] = 20'(gxe * gxe);
      sqy_d[ch] = 20'(gye * gye);
      t  = n_q[ch] | bitv;
      tt = 16'(t) * 16'(t);
      n_d[ch] = (21'(tt) <= s_q[ch]) ? t : n_q[ch];
      nn = 17'(n_q[ch]) * 17'(n_q[ch]) + 17'(n_q[ch]);
      if (s_q[ch] >= SatLimit) begin
        mag_d[ch] = MagMax;
      end else if (s_q[ch] > 21'(nn)) begin
        mag_d[ch] = n_q[ch] + 8'd1;
      end else begin
        mag_d[ch] = n_q[ch];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE:  if (start_i) state_d = M_GRAD;
      M_GRAD:  state_d = M_SQR;
      M_SQR:   state_d = M_SUM;
      M_SUM:   state_d = M_ROOT;
      M_ROOT:  if (it_q == 3'd7) state_d = M_ROUND;
      M_ROUND: state_d = M_HOLD;
      M_HOLD:  if (out_ready_i) state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      win_q  <= win_i;
      last_q <= last_i;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (state_q == M_GRAD) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
      if (state_q == M_SQR) begin
        sqx_q[ch] <= sqx_d[ch];
        sqy_q[ch] <= sqy_d[ch];
      end
      if (state_q == M_SUM) begin
        s_q[ch] <= 21'(sqx_q[ch]) + 21'(sqy_q[ch]);
        n_q[ch] <= '0;
      end
      if (state_q == M_ROOT) begin
        n_q[ch] <= n_d[ch];
      end
    end
    if (state_q == M_ROUND) begin
      res_q.red_mag    <= mag_d[ChRed];
      res_q.green_mag  <= mag_d[ChGreen];
      res_q.blue_mag   <= mag_d[ChBlue];
      res_q.frame_last <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == M_ROOT) begin
        it_q <= it_q + 3'd1;
      end else begin
        it_q <= '0;
      end
    end
  end

endmodule
